[sv/mclp_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-click and long-press detector package
// Shared types, codes and reset values for the button detector.
// ----------------------------------------------------------------------------
package mclp_pkg;

    localparam int unsigned TimeW   = 16;
    localparam int unsigned CountW  = 3;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CountW-1:0] MaxClicks = 3'd5;

    localparam logic [TimeW-1:0] ClickGapReset      = 16'd300;
    localparam logic [TimeW-1:0] LongPushReset      = 16'd2000;
    localparam logic [TimeW-1:0] ReallyLongPushReset = 16'd4000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CLICK_GAP        = 2'd0,
        CFG_LONG_PUSH        = 2'd1,
        CFG_REALLY_LONG_PUSH = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_LONG        = 3'd6,
        EV_REALLY_LONG = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        IND_LEAVE = 2'd0,
        IND_CLEAR = 2'd1,
        IND_SHOW  = 2'd2
    } indicator_t;

    typedef struct packed {
        logic [TimeW-1:0] click_gap_ms;
        logic [TimeW-1:0] long_push_ms;
        logic [TimeW-1:0] really_long_push_ms;
    } limits_t;

    typedef struct packed {
        logic             pin_level;
        logic [TimeW-1:0] now_ms;
        logic             frame_odd;
    } poll_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic [1:0] indicator_action;
    } result_t;

endpackage

[sv/mclp_if.sv]
// ----------------------------------------------------------------------------
// Multi-click and long-press detector channels
// Poll, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mclp_poll_if;
    logic                       valid;
    logic                       ready;
    logic                       pin_level;
    logic [mclp_pkg::TimeW-1:0] now_ms;
    logic                       frame_odd;

    modport source (output valid, output pin_level, output now_ms, output frame_odd,
                    input ready);
    modport sink (input valid, input pin_level, input now_ms, input frame_odd,
                  output ready);
endinterface

interface mclp_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [1:0] indicator_action;

    modport source (output valid, output event_code, output indicator_action,
                    input ready);
    modport sink (input valid, input event_code, input indicator_action,
                  output ready);
endinterface

interface mclp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mclp_pkg::CfgIdxW-1:0] index;
    logic [mclp_pkg::TimeW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/mclp_core.sv]
// ----------------------------------------------------------------------------
// Multi-click and long-press detector core
// Holds the button state and turns one poll into one result per step.
// ----------------------------------------------------------------------------
module mclp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mclp_pkg::poll_t   poll_item,
    input  mclp_pkg::limits_t limits,
    output mclp_pkg::result_t result_item
);

    logic                        held_reg;
    logic                        held_next;
    logic [mclp_pkg::CountW-1:0] click_count_reg;
    logic [mclp_pkg::CountW-1:0] click_count_next;
    logic [mclp_pkg::TimeW-1:0]  press_time_reg;
    logic [mclp_pkg::TimeW-1:0]  press_time_next;
    logic [mclp_pkg::TimeW-1:0]  age;
    logic                        pending;
    logic                        past_gap;
    logic                        past_long;
    logic                        past_really_long;
    logic [2:0]                  ev;
    logic [1:0]                  ind;

    assign age              = poll_item.now_ms - press_time_reg;
    assign pending          = (click_count_reg != '0);
    assign past_gap         = (age > limits.click_gap_ms);
    assign past_long        = (age > limits.long_push_ms);
    assign past_really_long = (age > limits.really_long_push_ms);

    always_comb
    begin
        held_next        = held_reg;
        click_count_next = click_count_reg;
        press_time_next  = press_time_reg;
        ev               = mclp_pkg::EV_NONE;
        ind              = mclp_pkg::IND_LEAVE;
        if (!held_reg)
        begin
            if (poll_item.pin_level)
            begin
                held_next       = 1'b1;
                press_time_next = poll_item.now_ms;
                if (click_count_reg < mclp_pkg::MaxClicks)
                begin
                    click_count_next = click_count_reg + 1'b1;
                end
            end
            else if (pending)
            begin
                if (past_really_long)
                begin
                    ev = mclp_pkg::EV_REALLY_LONG;
                end
                else if (past_long)
                begin
                    ev = mclp_pkg::EV_LONG;
                end
                else if (past_gap)
                begin
                    ev = click_count_reg;
                end
                if (ev != mclp_pkg::EV_NONE)
                begin
                    click_count_next = '0;
                end
            end
        end
        else if (!poll_item.pin_level)
        begin
            held_next = 1'b0;
            if (pending && past_long)
            begin
                ind = mclp_pkg::IND_CLEAR;
            end
        end
        else if (pending)
        begin
            if (past_really_long)
            begin
                ind = mclp_pkg::IND_SHOW;
            end
            else if (past_long)
            begin
                ind = poll_item.frame_odd ? mclp_pkg::IND_CLEAR : mclp_pkg::IND_SHOW;
            end
        end
    end

    assign result_item.event_code       = ev;
    assign result_item.indicator_action = ind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            click_count_reg <= '0;
            press_time_reg  <= '0;
        end
        else if (step)
        begin
            held_reg        <= held_next;
            click_count_reg <= click_count_next;
            press_time_reg  <= press_time_next;
        end
    end

endmodule

[sv/multi_click_long_press_detector.sv]
// ----------------------------------------------------------------------------
// Multi-click and long-press detector
// Reports click counts and long pushes from polled button samples.
// ----------------------------------------------------------------------------
// The poll channel takes one transaction per sample: the button level, a
// wrapping millisecond time and the display frame parity. Each poll gives
// exactly one transaction on the result channel, carrying an event code and
// an indicator action, in poll order.
// A poll is captured in an input register, evaluated against the button
// state and lands in the result register. One poll is taken every cycle
// while the result channel does not stall; the rate is set by the state
// update in the core.
// When the receiver stalls, the result register holds its transaction and
// the input register fills; the poll channel then drops ready until the
// result is taken.
// The configuration channel is always ready and writes the click gap, long
// push and really long push limits; the user must write it only while no
// poll is in flight, which the block does not enforce. Reset restores the
// limits to 300, 2000 and 4000 ms, releases the button state, clears the
// click count and empties both registers.
// ----------------------------------------------------------------------------
module multi_click_long_press_detector (
    input  logic        clk,
    input  logic        rst_n,
    mclp_poll_if.sink   poll,
    mclp_result_if.source result,
    mclp_cfg_if.sink    cfg
);

    mclp_pkg::limits_t limits_reg;
    mclp_pkg::poll_t   poll_reg;
    logic              poll_valid_reg;
    mclp_pkg::result_t result_reg;
    mclp_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              advance;

    assign advance    = poll_valid_reg && (!result_valid_reg || result.ready);
    assign poll.ready = !poll_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.click_gap_ms        <= mclp_pkg::ClickGapReset;
            limits_reg.long_push_ms        <= mclp_pkg::LongPushReset;
            limits_reg.really_long_push_ms <= mclp_pkg::ReallyLongPushReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mclp_pkg::CFG_CLICK_GAP:        limits_reg.click_gap_ms <= cfg.data;
                mclp_pkg::CFG_LONG_PUSH:        limits_reg.long_push_ms <= cfg.data;
                mclp_pkg::CFG_REALLY_LONG_PUSH: limits_reg.really_long_push_ms <= cfg.data;
                default:                        limits_reg <= limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            poll_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            poll_reg.pin_level <= poll.pin_level;
            poll_reg.now_ms    <= poll.now_ms;
            poll_reg.frame_odd <= poll.frame_odd;
        end
    end

    mclp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .poll_item   (poll_reg),
        .limits      (limits_reg),
        .result_item (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid            = result_valid_reg;
    assign result.event_code       = result_reg.event_code;
    assign result.indicator_action = result_reg.indicator_action;

endmodule

[bench/mclp_event_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button event checker
// Watches the poll, result and configuration channels of the multi-click and
// long-press detector. It keeps its own copy of the button state and limits,
// predicts the event code and indicator action of every accepted poll, and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module mclp_event_check
    import mclp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mclp_poll_if   poll,
    mclp_result_if result,
    mclp_cfg_if    cfg,
    output int     mismatches,
    output int     results_due
);

    limits_t          limits;
    logic             held;
    logic [CountW-1:0] click_count;
    logic [TimeW-1:0] press_time;
    result_t          due_q[$];

    function automatic result_t predict_poll(input poll_t p);
        logic [TimeW-1:0] age;
        result_t          r;
        age = p.now_ms - press_time;
        r.event_code = EV_NONE;
        r.indicator_action = IND_LEAVE;
        if (!held)
        begin
            if (p.pin_level)
            begin
                held = 1'b1;
                press_time = p.now_ms;
                if (click_count < MaxClicks)
                    click_count = click_count + 1'b1;
            end
            else if (click_count != '0)
            begin
                if (age > limits.really_long_push_ms)
                    r.event_code = EV_REALLY_LONG;
                else if (age > limits.long_push_ms)
                    r.event_code = EV_LONG;
                else if (age > limits.click_gap_ms)
                    r.event_code = click_count;
                if (r.event_code != EV_NONE)
                    click_count = '0;
            end
        end
        else if (!p.pin_level)
        begin
            if (click_count != '0 && age > limits.long_push_ms)
                r.indicator_action = IND_CLEAR;
            held = 1'b0;
        end
        else if (click_count != '0)
        begin
            if (age > limits.really_long_push_ms)
                r.indicator_action = IND_SHOW;
            else if (age > limits.long_push_ms)
                r.indicator_action = p.frame_odd ? IND_CLEAR : IND_SHOW;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        poll_t   p;
        if (!rst_n)
        begin
            limits.click_gap_ms = ClickGapReset;
            limits.long_push_ms = LongPushReset;
            limits.really_long_push_ms = ReallyLongPushReset;
            held = 1'b0;
            click_count = '0;
            press_time = '0;
            due_q.delete();
            mismatches = 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CLICK_GAP:        limits.click_gap_ms = cfg.data;
                    CFG_LONG_PUSH:        limits.long_push_ms = cfg.data;
                    CFG_REALLY_LONG_PUSH: limits.really_long_push_ms = cfg.data;
                    default:              ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (due_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: result transaction with none expected, got event %0d ind %0d",
                             $time, result.event_code, result.indicator_action);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (result.event_code !== want.event_code)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: event_code expected %0d, got %0d",
                                 $time, want.event_code, result.event_code);
                    end
                    if (result.indicator_action !== want.indicator_action)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: indicator_action expected %0d, got %0d",
                                 $time, want.indicator_action, result.indicator_action);
                    end
                end
            end
            if (poll.valid && poll.ready)
            begin
                p.pin_level = poll.pin_level;
                p.now_ms = poll.now_ms;
                p.frame_odd = poll.frame_odd;
                due_q.push_back(predict_poll(p));
            end
            results_due <= due_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-click and long-press detector testbench
// Drives polls shaped as click bursts, long holds and random noise under
// several limit settings, with random gaps and stalls on both channels and
// one long receiver hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import mclp_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int PhasePolls = 105;
    localparam int HoldOffCycles = 80;
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   results_due;
    int   cycles = 0;
    int   polls_sent = 0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;

    logic [TimeW-1:0] clock_ms = '0;
    logic [TimeW-1:0] last_press = '0;
    int unsigned      cur_gap = 32'(ClickGapReset);
    int unsigned      cur_long = 32'(LongPushReset);
    int unsigned      cur_rl = 32'(ReallyLongPushReset);

    mclp_poll_if   poll_ch ();
    mclp_result_if res_ch ();
    mclp_cfg_if    cfg_ch ();

    multi_click_long_press_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    mclp_event_check event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll        (poll_ch),
        .result      (res_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_poll(input logic pin, input logic [TimeW-1:0] now, input logic odd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid <= 1'b1;
        poll_ch.pin_level <= pin;
        poll_ch.now_ms <= now;
        poll_ch.frame_odd <= odd;
        do @(posedge clk); while (!poll_ch.ready);
        polls_sent++;
    endtask

    task automatic drain();
        poll_ch.valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [TimeW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic write_limits(input int unsigned gap, input int unsigned lng,
                                input int unsigned rl, input bit poke_unused);
        write_reg(CFG_CLICK_GAP, TimeW'(gap));
        write_reg(CFG_LONG_PUSH, TimeW'(lng));
        write_reg(CFG_REALLY_LONG_PUSH, TimeW'(rl));
        if (poke_unused)
            write_reg(CfgUnused, TimeW'($urandom_range(0, 65535)));
        cfg_ch.valid <= 1'b0;
        cur_gap = gap;
        cur_long = lng;
        cur_rl = rl;
    endtask

    function automatic int unsigned any_limit();
        case ($urandom_range(0, 2))
            0:       return cur_gap;
            1:       return cur_long;
            default: return cur_rl;
        endcase
    endfunction

    // Ages land on a limit, just past it, below it or somewhat beyond it.
    function automatic int unsigned pick_age(input int unsigned limit);
        case ($urandom_range(0, 3))
            0:       return limit;
            1:       return limit + 1;
            2:       return $urandom_range(0, limit);
            default: return limit + $urandom_range(0, limit / 4 + 2);
        endcase
    endfunction

    task automatic idle_polls();
        repeat ($urandom_range(1, 4))
        begin
            clock_ms = last_press + TimeW'(pick_age(any_limit()));
            send_poll(1'b0, clock_ms, coin());
        end
    endtask

    task automatic run_gesture();
        int kind;
        int unsigned step;
        kind = $urandom_range(0, 8);
        step = cur_gap / 3 + 3;
        if (kind < 5)
        begin
            repeat ($urandom_range(1, 7))
            begin
                clock_ms = clock_ms + TimeW'($urandom_range(0, step));
                last_press = clock_ms;
                send_poll(1'b1, clock_ms, coin());
                repeat ($urandom_range(0, 2))
                begin
                    clock_ms = clock_ms + TimeW'($urandom_range(0, step));
                    send_poll(1'b1, clock_ms, coin());
                end
                clock_ms = clock_ms + TimeW'($urandom_range(0, step));
                send_poll(1'b0, clock_ms, coin());
            end
            idle_polls();
        end
        else if (kind < 8)
        begin
            clock_ms = clock_ms + TimeW'($urandom_range(0, step));
            last_press = clock_ms;
            send_poll(1'b1, clock_ms, coin());
            repeat ($urandom_range(2, 6))
            begin
                clock_ms = last_press
                           + TimeW'(pick_age($urandom_range(0, 1) ? cur_long : cur_rl));
                send_poll(1'b1, clock_ms, coin());
            end
            clock_ms = last_press + TimeW'(pick_age(cur_long));
            send_poll(1'b0, clock_ms, coin());
            idle_polls();
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_poll(coin(), TimeW'($urandom_range(0, 65535)), coin());
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HoldOffCycles;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial
    begin : stimulus
        int target;
        rst_n <= 1'b0;
        poll_ch.valid <= 1'b0;
        poll_ch.pin_level <= 1'b0;
        poll_ch.now_ms <= '0;
        poll_ch.frame_odd <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_CLICK_GAP;
        cfg_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_poll(1'b0, 16'd0, 1'b0);
        send_poll(1'b1, 16'd100, 1'b1);
        send_poll(1'b1, 16'd200, 1'b0);
        send_poll(1'b0, 16'd250, 1'b1);
        send_poll(1'b0, 16'd400, 1'b0);
        send_poll(1'b0, 16'd401, 1'b1);
        send_poll(1'b1, 16'd1000, 1'b0);
        send_poll(1'b0, 16'd1050, 1'b0);
        send_poll(1'b1, 16'd1100, 1'b1);
        send_poll(1'b0, 16'd1150, 1'b0);
        send_poll(1'b0, 16'd1500, 1'b0);
        send_poll(1'b1, 16'd2000, 1'b0);
        send_poll(1'b1, 16'd4001, 1'b1);
        send_poll(1'b1, 16'd4002, 1'b0);
        send_poll(1'b1, 16'd6001, 1'b1);
        send_poll(1'b0, 16'd6100, 1'b0);
        send_poll(1'b0, 16'd6200, 1'b1);
        send_poll(1'b1, 16'd7000, 1'b0);
        send_poll(1'b0, 16'd7100, 1'b1);
        send_poll(1'b0, 16'd9500, 1'b0);
        send_poll(1'b1, 16'd65535, 1'b1);
        send_poll(1'b0, 16'd0, 1'b0);
        send_poll(1'b0, 16'd400, 1'b1);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_limits(20, 60, 120, 1'b0);
                1: write_limits(0, 0, 0, 1'b0);
                2: write_limits(65535, 65535, 65535, 1'b0);
                3: write_limits(3000, 1000, 500, 1'b1);
                4: write_limits($urandom_range(0, 500), $urandom_range(0, 4000),
                                $urandom_range(0, 8000), 1'b0);
                default: write_limits(32'(ClickGapReset), 32'(LongPushReset),
                                      32'(ReallyLongPushReset), 1'b0);
            endcase
            target = polls_sent + PhasePolls;
            if (phase == 0)
            begin
                quiet = 1'b1;
                hold_req = 1'b1;
                repeat (6) run_gesture();
            end
            while (polls_sent < target)
            begin
                quiet = ($urandom_range(0, 4) == 0);
                run_gesture();
            end
            quiet = 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[multi_click_long_press_detector.f]
sv/mclp_pkg.sv
sv/mclp_if.sv
sv/mclp_core.sv
sv/multi_click_long_press_detector.sv
bench/mclp_event_check.sv
bench/tb_top.sv
